// ===== rtl/gcm_pkg.sv =====
// Shared constants, types and helpers for the greedy coin change block.
// No dependencies; every other file refers to it by scoped names.
package gcm_pkg;

  // Sizing
  localparam int NUM_SLOTS    = 8;   // slots taking part in the search (1..8)
  localparam int AMOUNT_WIDTH = 16;  // width of the working amount (8..32)
  localparam int SLOT_REGS    = 8;   // denomination registers held
  localparam int COIN_W       = 16;
  localparam int FIELD_W      = 16;
  localparam int CFG_IDX_W    = 4;
  localparam int SLOT_IDX_W   = $clog2(SLOT_REGS);
  localparam int DIV_CNT_W    = $clog2(AMOUNT_WIDTH + 1);
  localparam int REM_W        = COIN_W + 1;
  localparam int SAT_W        = AMOUNT_WIDTH + FIELD_W;

  typedef logic [COIN_W-1:0]       coin_t;
  typedef coin_t [SLOT_REGS-1:0]   coin_arr_t;
  typedef logic [AMOUNT_WIDTH-1:0] amount_t;
  typedef logic [FIELD_W-1:0]      field_t;
  typedef logic [SLOT_IDX_W-1:0]   slot_idx_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

  localparam field_t FIELD_MAX = '1;

  // Denominations after reset, slot 0 first
  localparam coin_t COIN_RESET [SLOT_REGS] = '{
    16'd1, 16'd2, 16'd5, 16'd10, 16'd20, 16'd50, 16'd100, 16'd200
  };

  // Divider handshake status
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Clamp a working-width value to an output field
  function automatic field_t sat_field(amount_t v);
    logic [SAT_W-1:0] wide;
    wide = SAT_W'(v);
    if (wide > SAT_W'(FIELD_MAX)) begin
      return FIELD_MAX;
    end
    return FIELD_W'(v);
  endfunction

endpackage

// ===== rtl/gcm_in_if.sv =====
// Request channel: one beat carries the target amount.
// Depends on gcm_pkg.
interface gcm_in_if;
  logic                      valid;
  logic                      ready;
  logic [gcm_pkg::FIELD_W-1:0] target_amount;

  modport source (output valid, output target_amount, input ready);
  modport sink   (input valid, input target_amount, output ready);
endinterface

// ===== rtl/gcm_out_if.sv =====
// Result channel: per-slot coin counts, total, leftover and impossible flag.
// Depends on gcm_pkg.
interface gcm_out_if;
  logic                        valid;
  logic                        ready;
  logic [gcm_pkg::FIELD_W-1:0] count_slot_0;
  logic [gcm_pkg::FIELD_W-1:0] count_slot_1;
  logic [gcm_pkg::FIELD_W-1:0] count_slot_2;
  logic [gcm_pkg::FIELD_W-1:0] count_slot_3;
  logic [gcm_pkg::FIELD_W-1:0] count_slot_4;
  logic [gcm_pkg::FIELD_W-1:0] count_slot_5;
  logic [gcm_pkg::FIELD_W-1:0] count_slot_6;
  logic [gcm_pkg::FIELD_W-1:0] count_slot_7;
  logic [gcm_pkg::FIELD_W-1:0] total_coins;
  logic [gcm_pkg::FIELD_W-1:0] leftover_amount;
  logic                        impossible;

  modport source (
    output valid, input ready,
    output count_slot_0, output count_slot_1, output count_slot_2, output count_slot_3,
    output count_slot_4, output count_slot_5, output count_slot_6, output count_slot_7,
    output total_coins, output leftover_amount, output impossible
  );
  modport sink (
    input valid, output ready,
    input count_slot_0, input count_slot_1, input count_slot_2, input count_slot_3,
    input count_slot_4, input count_slot_5, input count_slot_6, input count_slot_7,
    input total_coins, input leftover_amount, input impossible
  );
endinterface

// ===== rtl/gcm_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on gcm_pkg.
interface gcm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gcm_pkg::CFG_IDX_W-1:0] index;
  logic [gcm_pkg::COIN_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/gcm_coin_regs.sv =====
// Denomination register file, written through the configuration channel.
// Depends on gcm_pkg and gcm_cfg_if.
module gcm_coin_regs (
  input  logic               clk,
  input  logic               rst_n,
  gcm_cfg_if.sink            cfg,
  output gcm_pkg::coin_arr_t coin_o
);

  gcm_pkg::coin_arr_t coin_r;
  logic               wr_en;

  // Always able to take a write beat; out-of-range indexes are dropped
  assign cfg.ready = 1'b1;
  assign wr_en     = cfg.valid && cfg.ready &&
                     (cfg.index < gcm_pkg::CFG_IDX_W'(gcm_pkg::SLOT_REGS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gcm_pkg::SLOT_REGS; i++) begin
        coin_r[i] <= gcm_pkg::COIN_RESET[i];
      end
    end else if (wr_en) begin
      coin_r[cfg.index[gcm_pkg::SLOT_IDX_W-1:0]] <= cfg.data;
    end
  end

  assign coin_o = coin_r;

endmodule

// ===== rtl/gcm_pick.sv =====
// Picks the largest unvisited, non-zero denomination; lowest slot wins ties.
// Depends on gcm_pkg.
module gcm_pick (
  input  gcm_pkg::coin_arr_t          coin_i,
  input  logic [gcm_pkg::SLOT_REGS-1:0] visited_i,
  output logic                        found_o,
  output gcm_pkg::slot_idx_t          idx_o
);

  gcm_pkg::coin_t best_val;

  // Running maximum over the slots; strict compare keeps the lower slot
  always_comb begin
    found_o  = 1'b0;
    idx_o    = '0;
    best_val = '0;
    for (int i = 0; i < gcm_pkg::SLOT_REGS; i++) begin
      if ((i < gcm_pkg::NUM_SLOTS) && !visited_i[i] && (coin_i[i] != '0) &&
          (!found_o || (coin_i[i] > best_val))) begin
        found_o  = 1'b1;
        idx_o    = gcm_pkg::SLOT_IDX_W'(i);
        best_val = coin_i[i];
      end
    end
  end

endmodule

// ===== rtl/gcm_divider.sv =====
// Restoring divider, one quotient bit per cycle: amount / denomination.
// Depends on gcm_pkg.
module gcm_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  gcm_pkg::amount_t     dividend_i,
  input  gcm_pkg::coin_t       divisor_i,
  output gcm_pkg::amount_t     quotient_o,
  output gcm_pkg::amount_t     remainder_o,
  output gcm_pkg::div_status_t status_o
);

  logic                            busy_r;
  logic [gcm_pkg::DIV_CNT_W-1:0]   cnt_r;
  gcm_pkg::amount_t                quo_r;
  logic [gcm_pkg::REM_W-1:0]       rem_r;
  gcm_pkg::coin_t                  divisor_r;

  logic [gcm_pkg::REM_W-1:0]       rem_shift;
  logic [gcm_pkg::REM_W-1:0]       div_ext;
  logic                            ge;
  logic                            step;

  // One shift-compare-subtract step
  assign rem_shift = {rem_r[gcm_pkg::COIN_W-1:0], quo_r[gcm_pkg::AMOUNT_WIDTH-1]};
  assign div_ext   = {1'b0, divisor_r};
  assign ge        = (rem_shift >= div_ext);
  assign step      = busy_r && (cnt_r != '0);

  // Control: count the steps down, done on the cycle after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= gcm_pkg::DIV_CNT_W'(gcm_pkg::AMOUNT_WIDTH);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Datapath: dividend shifts out at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r     <= dividend_i;
      rem_r     <= '0;
      divisor_r <= divisor_i;
    end else if (step) begin
      quo_r <= {quo_r[gcm_pkg::AMOUNT_WIDTH-2:0], ge};
      rem_r <= ge ? (rem_shift - div_ext) : rem_shift;
    end
  end

  assign quotient_o    = quo_r;
  assign remainder_o   = gcm_pkg::AMOUNT_WIDTH'(rem_r);
  assign status_o.busy = busy_r;
  assign status_o.done = busy_r && (cnt_r == '0);

endmodule

// ===== rtl/greedy_change_maker_core.sv =====
// Greedy coin change top level: sequencer, working registers, result register.
// Each request beat is split by picking the largest unvisited non-zero slot and dividing,
// one pass per non-zero slot on the shared bit-serial divider; the result register is then loaded.
// A new request is taken only in idle, after the previous result has been loaded.
// Synchronous active-low reset: denominations return to 1,2,5,10,20,50,100,200,
// sequencer idles and no result is held.
module greedy_change_maker_core (
  input  logic       clk,
  input  logic       rst_n,
  gcm_in_if.sink     in_ch,
  gcm_out_if.source  out_ch,
  gcm_cfg_if.sink    cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PICK  = 4'b0010,
    S_DIV   = 4'b0100,
    S_WRITE = 4'b1000
  } seq_state_t;

  seq_state_t                      state_r, state_nxt;
  logic [gcm_pkg::SLOT_REGS-1:0]   visited_r;
  gcm_pkg::slot_idx_t              best_idx_r;
  gcm_pkg::amount_t                remaining_r;
  gcm_pkg::amount_t                total_r;
  gcm_pkg::amount_t                count_r [gcm_pkg::SLOT_REGS];

  logic                            out_valid_r, out_valid_nxt;
  gcm_pkg::field_t                 out_count_r [gcm_pkg::SLOT_REGS];
  gcm_pkg::field_t                 out_total_r;
  gcm_pkg::field_t                 out_left_r;
  logic                            out_imp_r;

  gcm_pkg::coin_arr_t              coin;
  logic                            pick_found;
  gcm_pkg::slot_idx_t              pick_idx;
  logic                            div_start;
  gcm_pkg::amount_t                div_quo;
  gcm_pkg::amount_t                div_rem;
  gcm_pkg::div_status_t            div_st;

  logic                            in_accept;
  logic                            commit;
  logic                            out_free;
  logic                            out_load;

  // Denomination registers
  gcm_coin_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_ch),
    .coin_o (coin)
  );

  // Next slot to visit
  gcm_pick u_pick (
    .coin_i    (coin),
    .visited_i (visited_r),
    .found_o   (pick_found),
    .idx_o     (pick_idx)
  );

  // Shared divider
  gcm_divider u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (div_start),
    .dividend_i  (remaining_r),
    .divisor_i   (coin[pick_idx]),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .status_o    (div_st)
  );

  // Handshake terms
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign div_start   = (state_r == S_PICK) && pick_found;
  assign commit      = (state_r == S_DIV) && div_st.done;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = (state_r == S_WRITE) && out_free;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_PICK;
      S_PICK:  state_nxt = pick_found ? S_DIV : S_WRITE;
      S_DIV:   if (div_st.done) state_nxt = S_PICK;
      S_WRITE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register keeps its beat until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        visited_r <= '0;
      end else if (commit) begin
        visited_r[best_idx_r] <= 1'b1;
      end
    end
  end

  // Working registers: amount left, running total, per-slot counts
  always_ff @(posedge clk) begin
    if (in_accept) begin
      remaining_r <= gcm_pkg::AMOUNT_WIDTH'(in_ch.target_amount);
      total_r     <= '0;
      for (int i = 0; i < gcm_pkg::SLOT_REGS; i++) begin
        count_r[i] <= '0;
      end
    end else if (commit) begin
      remaining_r         <= div_rem;
      total_r             <= total_r + div_quo;
      count_r[best_idx_r] <= div_quo;
    end
    if (div_start) begin
      best_idx_r <= pick_idx;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < gcm_pkg::SLOT_REGS; i++) begin
        out_count_r[i] <= gcm_pkg::sat_field(count_r[i]);
      end
      out_total_r <= gcm_pkg::sat_field(total_r);
      out_left_r  <= gcm_pkg::FIELD_W'(remaining_r);
      out_imp_r   <= (remaining_r != '0);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.count_slot_0    = out_count_r[0];
  assign out_ch.count_slot_1    = out_count_r[1];
  assign out_ch.count_slot_2    = out_count_r[2];
  assign out_ch.count_slot_3    = out_count_r[3];
  assign out_ch.count_slot_4    = out_count_r[4];
  assign out_ch.count_slot_5    = out_count_r[5];
  assign out_ch.count_slot_6    = out_count_r[6];
  assign out_ch.count_slot_7    = out_count_r[7];
  assign out_ch.total_coins     = out_total_r;
  assign out_ch.leftover_amount = out_left_r;
  assign out_ch.impossible      = out_imp_r;

`ifndef SYNTH
  // Divider finishes only while the sequencer waits on it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV))
    else $error("divider done outside division state");

  // Each committed pass marks exactly one new slot
  a_visit_one: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> ($countones(visited_r) == $past($countones(visited_r)) + 1))
    else $error("visited set did not grow by one");

  // Amount left never grows over a pass
  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (remaining_r <= $past(remaining_r)))
    else $error("remaining amount increased");

  // A new request starts from a clean slate
  a_fresh_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> ((total_r == '0) && (visited_r == '0)))
    else $error("working state not cleared on request");

  // The picker never returns a slot already visited
  a_no_revisit: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !visited_r[pick_idx])
    else $error("slot visited twice");
`endif

endmodule

// ===== bench/gcm_change_checker.sv =====
// Scoreboard for the greedy coin change core: mirrors the denomination registers,
// predicts one change result per request beat and compares every result beat.
// Depends on gcm_pkg and the gcm_in_if, gcm_out_if and gcm_cfg_if interfaces.
module gcm_change_checker (
  input  logic clk,
  input  logic rst_n,
  gcm_in_if    in_ch,
  gcm_out_if   out_ch,
  gcm_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    gcm_pkg::field_t [gcm_pkg::SLOT_REGS-1:0] count;
    gcm_pkg::field_t                          total;
    gcm_pkg::field_t                          leftover;
    logic                                     impossible;
  } change_t;

  // Denominations after reset, slot 7 leftmost
  localparam gcm_pkg::coin_arr_t DENOM_AT_RESET = {
    16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1
  };

  gcm_pkg::coin_arr_t denom;
  change_t            change_q[$];

  // Clamp a 32-bit count to a 16-bit output field
  function automatic gcm_pkg::field_t clamp16(logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // Greedy split: largest unvisited non-zero slot first, lowest slot wins a tie
  function automatic change_t make_change(gcm_pkg::coin_arr_t coins,
                                          gcm_pkg::field_t target);
    logic [31:0] remaining;
    logic [31:0] q;
    logic [31:0] total;
    logic [31:0] cnt [gcm_pkg::SLOT_REGS];
    bit          taken [gcm_pkg::SLOT_REGS];
    int          best;
    int          pass;
    int          i;
    change_t     r;
    remaining = 32'(target);
    total     = '0;
    for (i = 0; i < gcm_pkg::SLOT_REGS; i++) begin
      cnt[i]   = '0;
      taken[i] = 1'b0;
    end
    for (pass = 0; pass < gcm_pkg::NUM_SLOTS; pass++) begin
      best = -1;
      for (i = 0; i < gcm_pkg::NUM_SLOTS; i++) begin
        if (!taken[i] && coins[i] != '0 && (best < 0 || coins[i] > coins[best])) begin
          best = i;
        end
      end
      if (best >= 0) begin
        taken[best] = 1'b1;
        q           = remaining / 32'(coins[best]);
        cnt[best]   = q;
        remaining   = remaining - q * 32'(coins[best]);
        total       = total + q;
      end
    end
    for (i = 0; i < gcm_pkg::SLOT_REGS; i++) begin
      r.count[i] = clamp16(cnt[i]);
    end
    r.total      = clamp16(total);
    r.leftover   = remaining[15:0];
    r.impossible = (remaining != '0);
    return r;
  endfunction

  // Report one field that differs
  task automatic note_mismatch(string fld, int unsigned want, int unsigned got);
    $display("%0t %s expected %0d got %0d", $time, fld, want, got);
  endtask

  // Watch all three channels on the same edge the core samples them
  always @(posedge clk) begin : watch
    change_t want;
    change_t got;
    int      errs;
    int      i;
    errs = 0;
    if (!rst_n) begin
      denom = DENOM_AT_RESET;
      change_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // register write; spare indexes are dropped
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < gcm_pkg::SLOT_REGS) begin
        denom[cfg_ch.index[gcm_pkg::SLOT_IDX_W-1:0]] = cfg_ch.data;
      end
      // request beat
      if (in_ch.valid && in_ch.ready) begin
        change_q.push_back(make_change(denom, in_ch.target_amount));
      end
      // result beat
      if (out_ch.valid && out_ch.ready) begin
        got.count[0]   = out_ch.count_slot_0;
        got.count[1]   = out_ch.count_slot_1;
        got.count[2]   = out_ch.count_slot_2;
        got.count[3]   = out_ch.count_slot_3;
        got.count[4]   = out_ch.count_slot_4;
        got.count[5]   = out_ch.count_slot_5;
        got.count[6]   = out_ch.count_slot_6;
        got.count[7]   = out_ch.count_slot_7;
        got.total      = out_ch.total_coins;
        got.leftover   = out_ch.leftover_amount;
        got.impossible = out_ch.impossible;
        if (change_q.size() == 0) begin
          errs++;
          $display("%0t result beat with no request outstanding, got total %0d leftover %0d",
                   $time, got.total, got.leftover);
        end else begin
          want = change_q.pop_front();
          for (i = 0; i < gcm_pkg::SLOT_REGS; i++) begin
            if (got.count[i] !== want.count[i]) begin
              errs++;
              note_mismatch($sformatf("count_slot_%0d", i), want.count[i], got.count[i]);
            end
          end
          if (got.total !== want.total) begin
            errs++;
            note_mismatch("total_coins", want.total, got.total);
          end
          if (got.leftover !== want.leftover) begin
            errs++;
            note_mismatch("leftover_amount", want.leftover, got.leftover);
          end
          if (got.impossible !== want.impossible) begin
            errs++;
            note_mismatch("impossible", want.impossible, got.impossible);
          end
        end
      end
      fail_count <= fail_count + errs;
      pending    <= change_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Top of the greedy coin change bench: clock, reset, request and register stimulus,
// result back-pressure, watchdog and verdict. Depends on gcm_pkg, the three channel
// interfaces, greedy_change_maker_core and gcm_change_checker.
module tb;

  // Register indexes
  localparam gcm_pkg::cfg_idx_t REG_COIN_0      = 4'd0;
  localparam gcm_pkg::cfg_idx_t REG_FIRST_SPARE = 4'd8;

  localparam int IDLE_LIMIT   = 20000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 100;

  // Back-pressure modes
  typedef enum int {
    RDY_ON      = 0,
    RDY_TOSS    = 1,
    RDY_STALL   = 2,
    RDY_PATTERN = 3
  } rdy_mode_t;

  logic      clk = 1'b0;
  logic      rst_n;
  int        fail_count;
  int        pending;
  int        burst_left;
  int        idle_cycles;
  rdy_mode_t rdy_mode;
  int        rdy_run;
  int        rdy_tick;

  gcm_in_if  in_ch ();
  gcm_out_if out_ch ();
  gcm_cfg_if cfg_ch ();

  greedy_change_maker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  gcm_change_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result back-pressure: runs of always-ready, coin-toss, hard stall and a fixed pattern
  always @(posedge clk) begin
    if (rdy_run == 0) begin
      rdy_mode = rdy_mode_t'($urandom_range(0, 3));
      rdy_run  = (rdy_mode == RDY_STALL) ? $urandom_range(1, 300) : $urandom_range(1, 400);
    end else begin
      rdy_run--;
    end
    rdy_tick++;
    case (rdy_mode)
      RDY_ON: begin
        out_ch.ready <= 1'b1;
      end
      RDY_TOSS: begin
        out_ch.ready <= $urandom_range(0, 1);
      end
      RDY_STALL: begin
        out_ch.ready <= 1'b0;
      end
      default: begin
        out_ch.ready <= (rdy_tick % 7) != 0;
      end
    endcase
  end

  // Watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One request beat; the sender may pause between bursts
  task automatic send_target(gcm_pkg::field_t amount);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_ch.valid         <= 1'b1;
    in_ch.target_amount <= amount;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // Stop requests and wait until every result has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write beat; valid stays up for a following write
  task automatic write_coin(gcm_pkg::cfg_idx_t idx, gcm_pkg::coin_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Load all eight slots (slot 7 leftmost), then release the channel
  task automatic set_coins(gcm_pkg::coin_arr_t coins);
    int i;
    for (i = 0; i < gcm_pkg::SLOT_REGS; i++) begin
      write_coin(gcm_pkg::cfg_idx_t'(REG_COIN_0 + i), coins[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Random amount, biased to the edges and to small values
  function automatic gcm_pkg::field_t pick_target();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return 16'd0;
    end else if (sel == 1) begin
      return 16'hFFFF;
    end else if (sel <= 4) begin
      return gcm_pkg::field_t'($urandom_range(0, 500));
    end
    return gcm_pkg::field_t'($urandom);
  endfunction

  // Random denominations: unused slots, ties, small, mid and full-range values
  function automatic gcm_pkg::coin_arr_t pick_coins();
    gcm_pkg::coin_arr_t c;
    int                 i;
    int                 sel;
    for (i = 0; i < gcm_pkg::SLOT_REGS; i++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: c[i] = '0;
        1: c[i] = 16'hFFFF;
        2: c[i] = (i > 0) ? c[$urandom_range(0, i - 1)] : 16'd1;
        3, 4, 5: c[i] = gcm_pkg::coin_t'($urandom_range(1, 20));
        6, 7: c[i] = gcm_pkg::coin_t'($urandom_range(1, 1000));
        default: c[i] = gcm_pkg::coin_t'($urandom);
      endcase
    end
    return c;
  endfunction

  initial begin : stim
    int ph;
    int n;
    int k;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.target_amount <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= '0;
    cfg_ch.data         <= '0;
    burst_left  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset denominations: edges of the amount and alternating bit patterns
    send_target(16'd0);
    send_target(16'd1);
    send_target(16'd3);
    send_target(16'd199);
    send_target(16'd388);
    send_target(16'hFFFF);
    send_target(16'hAAAA);
    send_target(16'h5555);
    drain();

    // Every slot at the top value: a tie, slot 0 takes the coin
    set_coins({8{16'hFFFF}});
    send_target(16'hFFFF);
    send_target(16'hFFFE);
    send_target(16'd0);
    drain();

    // No usable slot: leftover is the whole amount
    set_coins({8{16'h0000}});
    send_target(16'd0);
    send_target(16'd1234);
    send_target(16'hFFFF);
    drain();

    // Single unit coin in the top slot: counts and total at full range
    set_coins({16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_target(16'hFFFF);
    send_target(16'h5555);
    drain();

    // Non-canonical set with gaps and ties: greedy is not optimal here
    set_coins({16'd0, 16'd3, 16'd0, 16'd1, 16'd4, 16'd3, 16'd0, 16'd4});
    send_target(16'd6);
    send_target(16'd7);
    send_target(16'hFFFF);
    drain();

    // Writes to indexes past the last slot must leave the slots alone
    for (k = 0; k < 8; k++) begin
      write_coin(gcm_pkg::cfg_idx_t'(REG_FIRST_SPARE + k), (k % 2 == 0) ? 16'd0 : 16'hFFFF);
    end
    cfg_ch.valid <= 1'b0;
    send_target(16'd100);
    send_target(16'hFFFF);
    drain();

    // Random phases; the first goes back to the reset set
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        set_coins({16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5, 16'd2, 16'd1});
      end else begin
        set_coins(pick_coins());
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_target(pick_target());
      end
      drain();
    end

    // Let any stray result show up
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gcm_pkg.sv
rtl/gcm_in_if.sv
rtl/gcm_out_if.sv
rtl/gcm_cfg_if.sv
rtl/gcm_coin_regs.sv
rtl/gcm_pick.sv
rtl/gcm_divider.sv
rtl/greedy_change_maker_core.sv
bench/gcm_change_checker.sv
bench/tb.sv
